// ===== rtl/core/bffa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared sizes, codes and request, response and control types.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;
	localparam int WIDX_W     = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LVL_W      = $clog2(BIT_W + 1);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_SCAN,
		KIND_ALLOC_ZERO,
		KIND_ALLOC_LONG,
		KIND_FREE_OOB,
		KIND_FREE_ZERO,
		KIND_FREE_OK
	} req_kind_t;

	typedef struct packed {
		logic             mode;
		logic [BLK_W-1:0] start_block;
		logic [CNT_W-1:0] block_count;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] alloc_start;
		logic [CNT_W-1:0] free_blocks;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    setup;
		logic    mark;
		logic    reply;
		status_t code;
	} cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      hit;
		logic      scan_end;
		logic      mark_end;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bffa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator controller
// Sequences request decode, bitmap scan, run marking and the response.
// ----------------------------------------------------------------------------
module bffa_ctrl
	import bffa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_SETUP  = 5'b01000,
		S_MARK   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.kind)
					KIND_SCAN: begin
						state_d = S_SCAN;
					end
					KIND_FREE_OK: begin
						state_d = S_SETUP;
					end
					KIND_ALLOC_LONG: begin
						cmd.reply = 1'b1;
						cmd.code  = ST_NO_SPACE;
						state_d   = S_IDLE;
					end
					KIND_FREE_OOB: begin
						cmd.reply = 1'b1;
						cmd.code  = ST_RANGE;
						state_d   = S_IDLE;
					end
					default: begin
						cmd.reply = 1'b1;
						cmd.code  = ST_DONE;
						state_d   = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					state_d = S_SETUP;
				end else if (stat.scan_end) begin
					cmd.reply = 1'b1;
					cmd.code  = ST_NO_SPACE;
					state_d   = S_IDLE;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_MARK;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.mark_end) begin
					cmd.reply = 1'b1;
					cmd.code  = ST_DONE;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/bffa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator datapath
// Occupancy bitmap memory, word-at-a-time run search, run marking and the
// free-block counter.
// ----------------------------------------------------------------------------
module bffa_datapath
	import bffa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  done,
	output rsp_t  rsp
);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] map_vld_q;

	logic             mode_q;
	logic [BLK_W-1:0] start_q;
	logic [CNT_W-1:0] count_q;
	logic [BLK_W-1:0] lo_q;
	logic [BLK_W-1:0] hi_q;
	logic [BLK_W-1:0] astart_q;
	logic [CNT_W-1:0] run_q;
	logic [WIDX_W-1:0] rd_addr_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic [WORD_BITS-1:0] word_s1;
	logic                 vld_s1;
	logic [WIDX_W-1:0]    idx_s1;
	logic                 eval_s1;

	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lvl_bits [BIT_W+1];
	logic [WORD_BITS-1:0] fit_bits;
	logic [BIT_W:0]       low_free;
	logic [BIT_W:0]       high_free;
	logic [BIT_W-1:0]     fit_pos;
	logic [LVL_W-1:0]     lvl;
	logic [BIT_W-1:0]     lvl_shift;
	logic                 small_req;
	logic                 pref_hit;
	logic                 int_hit;
	logic [BLK_W-1:0]     base_blk;
	logic [BLK_W-1:0]     hit_start;
	logic [CNT_W-1:0]     run_next;
	logic [BLK_W-1:0]     mark_lo;
	logic [BIT_W-1:0]     lo_off;
	logic [BIT_W-1:0]     hi_off;
	logic [WORD_BITS-1:0] mark_mask;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;
	logic [CNT_W:0]       free_sum;
	logic [CNT_W:0]       range_end;
	logic [CNT_W-1:0]     cnt_next;
	req_kind_t            kind;

	function automatic logic [BIT_W:0] low_ones(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] n;
		n = (BIT_W + 1)'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				n = (BIT_W + 1)'(i);
			end
		end
		return n;
	endfunction

	function automatic logic [BIT_W:0] high_ones(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] n;
		n = (BIT_W + 1)'(WORD_BITS);
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!v[i]) begin
				n = (BIT_W + 1)'(WORD_BITS - 1 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = BIT_W'(i);
			end
		end
		return p;
	endfunction

	// Request classification.
	always_comb begin
		range_end = {2'b00, start_q} + {1'b0, count_q};
		if (mode_q == MODE_ALLOC) begin
			if (count_q == '0) begin
				kind = KIND_ALLOC_ZERO;
			end else if (count_q > CNT_W'(NUM_BLOCKS)) begin
				kind = KIND_ALLOC_LONG;
			end else begin
				kind = KIND_SCAN;
			end
		end else begin
			if (range_end > (CNT_W + 1)'(NUM_BLOCKS)) begin
				kind = KIND_FREE_OOB;
			end else if (count_q == '0) begin
				kind = KIND_FREE_ZERO;
			end else begin
				kind = KIND_FREE_OK;
			end
		end
	end

	// Run search over one bitmap word. A run that continues from earlier words
	// is checked against the free bits at the bottom of the word; a short run
	// that fits inside the word is found with two overlapping power-of-two
	// windows.
	always_comb begin
		cur_word  = vld_s1 ? word_s1 : '0;
		free_bits = ~cur_word;
		lvl_bits[0] = free_bits;
		for (int j = 1; j <= BIT_W; j++) begin
			lvl_bits[j] = lvl_bits[j-1] & (lvl_bits[j-1] >> (1 << (j - 1)));
		end
		lvl = '0;
		for (int j = 0; j <= BIT_W; j++) begin
			if (count_q[j]) begin
				lvl = LVL_W'(j);
			end
		end
		lvl_shift = BIT_W'(count_q - (CNT_W'(1) << lvl));
		small_req = (count_q <= CNT_W'(WORD_BITS)) && (count_q != '0);
		fit_bits  = lvl_bits[lvl] & (lvl_bits[lvl] >> lvl_shift);
		int_hit   = small_req && (fit_bits != '0);
		fit_pos   = lowest_set(fit_bits);
		low_free  = low_ones(free_bits);
		high_free = high_ones(free_bits);
		pref_hit  = ({1'b0, run_q} + (CNT_W + 1)'(low_free)) >= {1'b0, count_q};
		base_blk  = {idx_s1, BIT_W'(0)};
		hit_start = pref_hit ? (base_blk - run_q[BLK_W-1:0]) : (base_blk + BLK_W'(fit_pos));
		run_next  = (&free_bits) ? (run_q + CNT_W'(WORD_BITS)) : CNT_W'(high_free);
	end

	// Mask of the run's blocks within the word being marked.
	always_comb begin
		mark_lo   = (mode_q == MODE_FREE) ? start_q : astart_q;
		lo_off    = (idx_s1 == lo_q[BLK_W-1 -: WIDX_W]) ? lo_q[BIT_W-1:0] : '0;
		hi_off    = (idx_s1 == hi_q[BLK_W-1 -: WIDX_W]) ? hi_q[BIT_W-1:0] : '1;
		mark_mask = ({WORD_BITS{1'b1}} << lo_off)
			& ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_off));
		wr_data   = (mode_q == MODE_FREE) ? (cur_word & ~mark_mask) : (cur_word | mark_mask);
		wr_en     = cmd.mark && eval_s1;
	end

	always_comb begin
		free_sum = {1'b0, free_cnt_q} + {1'b0, count_q};
		cnt_next = free_cnt_q;
		if (cmd.code == ST_DONE) begin
			if (mode_q == MODE_FREE) begin
				cnt_next = (free_sum > (CNT_W + 1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
					: free_sum[CNT_W-1:0];
			end else begin
				cnt_next = (free_cnt_q >= count_q) ? (free_cnt_q - count_q) : '0;
			end
		end
	end

	always_comb begin
		stat.kind     = kind;
		stat.hit      = cmd.scan && eval_s1 && (pref_hit || int_hit);
		stat.scan_end = cmd.scan && eval_s1 && (idx_s1 == WIDX_W'(MAP_WORDS - 1));
		stat.mark_end = wr_en && (idx_s1 == hi_q[BLK_W-1 -: WIDX_W]);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[idx_s1] <= wr_data;
		end
		word_s1 <= map_mem[rd_addr_q];
		vld_s1  <= map_vld_q[rd_addr_q];
		idx_s1  <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q  <= '0;
			free_cnt_q <= CNT_W'(NUM_BLOCKS);
			eval_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan || cmd.mark;
			done_q  <= cmd.reply;
			if (wr_en) begin
				map_vld_q[idx_s1] <= 1'b1;
			end
			if (cmd.reply) begin
				free_cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= req.mode;
			start_q   <= req.start_block;
			count_q   <= req.block_count;
			run_q     <= '0;
			rd_addr_q <= '0;
			astart_q  <= '0;
		end
		if (cmd.scan) begin
			rd_addr_q <= rd_addr_q + 1'b1;
			if (eval_s1) begin
				run_q <= run_next;
				if (pref_hit || int_hit) begin
					astart_q <= hit_start;
				end
			end
		end
		if (cmd.setup) begin
			lo_q      <= mark_lo;
			hi_q      <= mark_lo + count_q[BLK_W-1:0] - 1'b1;
			rd_addr_q <= mark_lo[BLK_W-1 -: WIDX_W];
		end
		if (cmd.mark) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (cmd.reply) begin
			rsp_q.status      <= cmd.code;
			rsp_q.alloc_start <= ((cmd.code == ST_DONE) && (mode_q == MODE_ALLOC))
				? astart_q : '0;
			rsp_q.free_blocks <= cnt_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_W'(NUM_BLOCKS))
		else $error("free-block counter above the store size");

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> ({2'b00, hit_start} + {1'b0, count_q}) <= (CNT_W + 1)'(NUM_BLOCKS))
		else $error("found run extends past the store");

	a_mark_mask: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (mark_mask != '0))
		else $error("marked word has an empty mask");

	a_mark_word: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (idx_s1 >= lo_q[BLK_W-1 -: WIDX_W]) && (idx_s1 <= hi_q[BLK_W-1 -: WIDX_W]))
		else $error("marked word lies outside the run");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_first_fit_block_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Allocates and frees contiguous runs of blocks tracked in a one-bit-per-block
// occupancy bitmap, with a free-block counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its response appears
// on rsp for one cycle with done high, and the receiver cannot stall it. The
// bitmap memory is read one 32-block word per cycle, which sets the rate. An
// allocation scans the words until a run fits, then marks the run's words;
// one that finds no space scans the whole bitmap. A valid free marks the
// words of its run, and requests that are rejected, empty or out of range
// are answered from the decode state. The response appears in the first
// cycle with busy low, in which a new request may already be taken.
module bitmap_first_fit_block_allocator_unit
	import bffa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	bffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bffa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
